### design/pcg32_pkg.sv
package pcg32_pkg;

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    MODE_NEXT   = 2'd0,
    MODE_DIRECT = 2'd1,
    MODE_HASH   = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_e;

  typedef enum logic [0:0] {
    SQ_IDLE,
    SQ_RUN
  } sq_state_e;

  // Partial product issued to the 32x32 multiplier
  typedef enum logic [1:0] {
    PP_NONE,
    PP_LL,
    PP_LH,
    PP_HL
  } pp_e;

  // Multiplier constant
  typedef enum logic [1:0] {
    K_LCG,
    K_MIXA,
    K_MIXB
  } kon_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADDHI
  } acc_e;

  // Work register update
  typedef enum logic [2:0] {
    Z_HOLD,
    Z_SEED_A,
    Z_XS30,
    Z_ACC_XS27,
    Z_ACC_XS31
  } zop_e;

  // Architectural write-back
  typedef enum logic [1:0] {
    WR_NONE,
    WR_LCG_EMIT,
    WR_SPLIT
  } wr_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_END,
    JMP_LOOP
  } jmp_e;

  typedef struct packed {
    pp_e  pp;
    kon_e kon;
    acc_e acc;
    zop_e zop;
    wr_e  wr;
    jmp_e jmp;
  } uword_t;

  localparam int unsigned PcW = 5;

  localparam logic [PcW-1:0] HashEntry = 5'd0;
  localparam logic [PcW-1:0] HashLoop  = 5'd1;
  localparam logic [PcW-1:0] NextEntry = 5'd13;
  localparam logic [PcW-1:0] PgmLen    = 5'd18;

  localparam logic [63:0] LcgMult     = 64'h5851_f42d_4c95_7f2d;
  localparam logic [63:0] GoldenGamma = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] IncOffset   = 64'h5851_f42d_4c95_7f2d;
  localparam logic [63:0] MixMulA     = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MixMulB     = 64'h94d0_49bb_1331_11eb;
  localparam logic [63:0] StateReset  = 64'h853c_49e6_748f_ea9b;
  localparam logic [63:0] IncReset    = 64'hda3e_39cb_94b9_5bdb;

  // Control store: hashed seeding from step 0, next number from step 13
  function automatic uword_t ucode(logic [PcW-1:0] addr);
    uword_t w;
    w = '{pp: PP_NONE, kon: K_LCG, acc: ACC_NONE, zop: Z_HOLD, wr: WR_NONE, jmp: JMP_NEXT};
    case (addr)
      5'd0:  w.zop = Z_SEED_A;
      5'd1:  w.zop = Z_XS30;
      5'd2:  begin w.pp = PP_LL; w.kon = K_MIXA; end
      5'd3:  begin w.pp = PP_LH; w.kon = K_MIXA; w.acc = ACC_LOAD; end
      5'd4:  begin w.pp = PP_HL; w.kon = K_MIXA; w.acc = ACC_ADDHI; end
      5'd5:  w.acc = ACC_ADDHI;
      5'd6:  w.zop = Z_ACC_XS27;
      5'd7:  begin w.pp = PP_LL; w.kon = K_MIXB; end
      5'd8:  begin w.pp = PP_LH; w.kon = K_MIXB; w.acc = ACC_LOAD; end
      5'd9:  begin w.pp = PP_HL; w.kon = K_MIXB; w.acc = ACC_ADDHI; end
      5'd10: w.acc = ACC_ADDHI;
      5'd11: w.zop = Z_ACC_XS31;
      5'd12: begin w.wr = WR_SPLIT; w.jmp = JMP_LOOP; end
      5'd13: w.pp = PP_LL;
      5'd14: begin w.pp = PP_LH; w.acc = ACC_LOAD; end
      5'd15: begin w.pp = PP_HL; w.acc = ACC_ADDHI; end
      5'd16: w.acc = ACC_ADDHI;
      5'd17: begin w.wr = WR_LCG_EMIT; w.jmp = JMP_END; end
      default: w.jmp = JMP_END;
    endcase
    return w;
  endfunction

endpackage

### design/pcg32_generator_with_seeding.sv
// Channel  Dir  Handshake                      Payload (lowest bit up)
// s_axis   in   s_axis_tvalid/s_axis_tready    tuser: mode[1:0];
//                                              tdata: seed_value[63:0], increment_arg[127:64]
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata: random_value[31:0]
//
// A next request is accepted and then runs a 5-step microprogram that does the
// 64x64 LCG multiply as three 32x32 partial products through the one multiplier.
// A hashed seed runs two finaliser passes, two multiplies each; a direct seed or
// mode three completes in the accepting cycle.
// Reset loads the generator's default state and increment, no clearing pass.
// A result waits in the output register; the next request is taken meanwhile, and
// the program holds at its last step only while an earlier result is still unread.
module pcg32_generator_with_seeding (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // seed_value[63:0], increment_arg[127:64]
  input  logic [1:0]   s_axis_tuser,   // mode[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata    // random_value[31:0]
);

  pcg32_pkg::sq_state_e           sq_q, sq_d;
  logic [pcg32_pkg::PcW-1:0]      pc_q, pc_d;
  logic                           pass_q, pass_d;
  logic [63:0]                    state_q, state_d;
  logic [63:0]                    inc_q, inc_d;
  logic [63:0]                    z_q, z_d;       // work register, multiplicand
  logic [63:0]                    seed_q, seed_d;
  logic [63:0]                    acc_q, acc_d;
  logic [63:0]                    prod_q, prod_d;
  logic                           out_valid_q, out_valid_d;
  logic [31:0]                    out_q, out_d;

  pcg32_pkg::uword_t              uw;
  pcg32_pkg::mode_e               mode;
  logic [63:0]                    konst;
  logic [31:0]                    mul_a, mul_b;
  logic [31:0]                    xs;
  logic [63:0]                    xs_dup;
  logic [63:0]                    rot_wide;
  logic                           accept;
  logic                           hold;

  assign uw     = pcg32_pkg::ucode(pc_q);
  assign mode   = pcg32_pkg::mode_e'(s_axis_tuser);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (sq_q == pcg32_pkg::SQ_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Stall the emitting step while the previous result is still unread
  assign hold = (sq_q == pcg32_pkg::SQ_RUN) && (uw.wr == pcg32_pkg::WR_LCG_EMIT)
                && out_valid_q && !m_axis_tready;

  // Multiplier constant and operand halves
  always_comb begin
    case (uw.kon)
      pcg32_pkg::K_LCG:  konst = pcg32_pkg::LcgMult;
      pcg32_pkg::K_MIXA: konst = pcg32_pkg::MixMulA;
      pcg32_pkg::K_MIXB: konst = pcg32_pkg::MixMulB;
      default:           konst = pcg32_pkg::LcgMult;
    endcase
  end

  assign mul_a  = (uw.pp == pcg32_pkg::PP_HL) ? z_q[63:32] : z_q[31:0];
  assign mul_b  = (uw.pp == pcg32_pkg::PP_LH) ? konst[63:32] : konst[31:0];
  assign prod_d = {32'd0, mul_a} * {32'd0, mul_b};

  // XSH-RR permutation of the old state, held in z during a next request
  assign xs       = 32'(((z_q >> 18) ^ z_q) >> 27);
  assign xs_dup   = {xs, xs};
  assign rot_wide = xs_dup >> z_q[63:59];

  always_comb begin
    sq_d        = sq_q;
    pc_d        = pc_q;
    pass_d      = pass_q;
    state_d     = state_q;
    inc_d       = inc_q;
    z_d         = z_q;
    seed_d      = seed_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    case (sq_q)
      pcg32_pkg::SQ_IDLE: begin
        if (accept) begin
          case (mode)
            pcg32_pkg::MODE_NEXT: begin
              z_d  = state_q;
              pc_d = pcg32_pkg::NextEntry;
              sq_d = pcg32_pkg::SQ_RUN;
            end
            pcg32_pkg::MODE_DIRECT: begin
              state_d = s_axis_tdata[63:0];
              inc_d   = {s_axis_tdata[126:64], 1'b1};
            end
            pcg32_pkg::MODE_HASH: begin
              seed_d = s_axis_tdata[63:0];
              pass_d = 1'b0;
              pc_d   = pcg32_pkg::HashEntry;
              sq_d   = pcg32_pkg::SQ_RUN;
            end
            default: ;  // drop mode three
          endcase
        end
      end
      pcg32_pkg::SQ_RUN: begin
        if (!hold) begin
          case (uw.acc)
            pcg32_pkg::ACC_LOAD:  acc_d = prod_q;
            pcg32_pkg::ACC_ADDHI: acc_d = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
            default: ;
          endcase

          case (uw.zop)
            pcg32_pkg::Z_SEED_A:   z_d = seed_q + pcg32_pkg::GoldenGamma;
            pcg32_pkg::Z_XS30:     z_d = z_q ^ (z_q >> 30);
            pcg32_pkg::Z_ACC_XS27: z_d = acc_q ^ (acc_q >> 27);
            pcg32_pkg::Z_ACC_XS31: z_d = acc_q ^ (acc_q >> 31);
            default: ;
          endcase

          pc_d = pc_q + 1'b1;
          case (uw.wr)
            pcg32_pkg::WR_LCG_EMIT: begin
              state_d     = acc_q + inc_q;
              out_d       = rot_wide[31:0];
              out_valid_d = 1'b1;
            end
            pcg32_pkg::WR_SPLIT: begin
              // first pass yields the state, second the increment
              if (!pass_q) begin
                state_d = z_q;
                z_d     = seed_q + pcg32_pkg::IncOffset;
                pass_d  = 1'b1;
              end else begin
                inc_d = z_q | 64'd1;
              end
            end
            default: ;
          endcase

          case (uw.jmp)
            pcg32_pkg::JMP_END: sq_d = pcg32_pkg::SQ_IDLE;
            pcg32_pkg::JMP_LOOP: begin
              if (!pass_q) begin
                pc_d = pcg32_pkg::HashLoop;
              end else begin
                sq_d = pcg32_pkg::SQ_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      default: sq_d = pcg32_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q        <= pcg32_pkg::SQ_IDLE;
      pc_q        <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= pcg32_pkg::StateReset;
      inc_q       <= pcg32_pkg::IncReset;
    end else begin
      sq_q        <= sq_d;
      pc_q        <= pc_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      inc_q       <= inc_d;
    end
  end

  // Datapath payload, no reset needed
  always_ff @(posedge clk_i) begin
    z_q    <= z_d;
    seed_q <= seed_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
    if (uw.pp != pcg32_pkg::PP_NONE) begin
      prod_q <= prod_d;
    end
  end

  // Increment stays odd whatever was seeded
  a_inc_odd: assert property (@(posedge clk_i) disable iff (!rst_ni) inc_q[0])
    else $error("stream increment lost its low bit");

  // Program counter stays inside the control store while running
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_q == pcg32_pkg::SQ_RUN) |-> (pc_q < pcg32_pkg::PgmLen))
    else $error("sequencer ran off the control store");

  // A next request starts the LCG program
  a_next_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == pcg32_pkg::MODE_NEXT)
      |=> (sq_q == pcg32_pkg::SQ_RUN && pc_q == pcg32_pkg::NextEntry))
    else $error("next request did not enter its program");

  // The emitting step always leaves a result on the output
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_q == pcg32_pkg::SQ_RUN && uw.wr == pcg32_pkg::WR_LCG_EMIT && !hold)
      |=> m_axis_tvalid)
    else $error("emit step produced no result");

endmodule
